// ----- hw/rtl/hpa_pkg.sv -----
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared constants, codes and types of the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

	localparam int MAX_SLOTS      = 256;
	localparam int POOL_CAP       = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
	localparam int ID_W           = 8;
	localparam int CNT_W          = 9;
	localparam int DEFAULT_GROWTH = 16;

	typedef enum logic [2:0] {
		MODE_ACQUIRE     = 3'd0,
		MODE_RELEASE     = 3'd1,
		MODE_PREWARM     = 3'd2,
		MODE_SHRINK      = 3'd3,
		MODE_CLEAR       = 3'd4,
		MODE_CONSTRUCT   = 3'd5,
		MODE_RELEASE_ALL = 3'd6,
		MODE_NOP         = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_NOT_ACTIVE = 2'd2,
		ST_RSVD       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		GROW_FIXED  = 2'd0,
		GROW_LINEAR = 2'd1,
		GROW_DOUBLE = 2'd2,
		GROW_HALF   = 2'd3
	} growth_t;

	localparam logic [1:0] REG_INITIAL_CAPACITY = 2'd0;
	localparam logic [1:0] REG_CAPACITY_LIMIT   = 2'd1;
	localparam logic [1:0] REG_GROWTH_MODE      = 2'd2;

	typedef struct packed {
		logic            set;
		logic            clr;
		logic            clr_all;
		logic [ID_W-1:0] idx;
	} id_cmd_t;

endpackage

// ----- hw/rtl/hpa_ram.sv -----
// ----------------------------------------------------------------------------
// hpa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpa_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/hpa_id_map.sv -----
// ----------------------------------------------------------------------------
// hpa_id_map
// One flag per handle id telling whether the id has been created.
// ----------------------------------------------------------------------------
module hpa_id_map
	import hpa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  id_cmd_t cmd,
	output logic    in_use
);

	logic [POOL_CAP-1:0] used_q;

	assign in_use = used_q[cmd.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clr_all) begin
			used_q <= '0;
		end else if (cmd.set) begin
			used_q[cmd.idx] <= 1'b1;
		end else if (cmd.clr) begin
			used_q[cmd.idx] <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/handle_pool_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// handle_pool_allocator_unit
// Handle pool with a LIFO free stack and an active list held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: register writes (index 0 initial capacity, 1 capacity limit,
//   2 growth mode), always ready; write only while the pool is idle.
//   req channel: one command per transfer (mode, handle_in, target_count).
//   rsp channel: exactly one result per command (handle_out, status, counts).
// Sequencing (a state machine walks the two RAMs, each with registered read data):
//   acquire pops the free stack; with none free it first grows the pool,
//   scanning ids for unused ones, up to 256.
//   release searches the active list entry by entry.
//   shrink drops free handles and release-all returns active ones, one at
//   a time; clear and no-op go straight to the result; prewarm and construct scan ids like growth.
//   One command is in flight at a time.
// Reset empties the pool and marks every id unused; RAM contents stay
// undefined and are only read below the stack lengths.
// A result waits in the output register while rsp_ready is low; the next
// command is taken but its result holds until the previous one transfers.
// ----------------------------------------------------------------------------
module handle_pool_allocator_unit
	import hpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [2:0]       mode,
	input  logic [ID_W-1:0]  handle_in,
	input  logic [CNT_W-1:0] target_count,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [ID_W-1:0]  handle_out,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] busy_count,
	output logic [CNT_W-1:0] free_count,
	output logic [CNT_W-1:0] total_count
);

	typedef enum logic [3:0] {
		S_IDLE, S_GROW, S_ACQ_CHK, S_ACQ_WR, S_REL_RD, S_REL_CMP, S_REL_MOVE,
		S_SHR, S_SHR_CLR, S_RALL, S_RALL_WR, S_DONE
	} state_t;

	localparam logic [CNT_W-1:0] CAP     = CNT_W'(POOL_CAP);
	localparam logic [CNT_W-1:0] DEF_GRW = CNT_W'(DEFAULT_GROWTH);

	state_t           state_q;
	logic [CNT_W-1:0] init_cap_q, cap_lim_q;
	logic [1:0]       grow_mode_q;
	logic [CNT_W-1:0] free_len_q, active_len_q;
	logic [CNT_W-1:0] cnt_q, id_q, idx_q, keep_q;
	logic             ret_acq_q;
	logic [ID_W-1:0]  handle_q, hout_q;
	status_t          st_q;
	logic             rsp_valid_q;
	logic [ID_W-1:0]  handle_out_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] act_out_q, free_out_q, tot_out_q;

	logic             fs_we, al_we;
	logic [ID_W-1:0]  fs_waddr, fs_wdata, fs_raddr, fs_rdata;
	logic [ID_W-1:0]  al_waddr, al_wdata, al_raddr, al_rdata;
	id_cmd_t          id_cmd;
	logic             id_used;

	logic [CNT_W-1:0] total, lim, room, amt_grow, amt_pre, req_amt, clip;
	logic [CNT_W:0]   half;

	hpa_ram #(.DEPTH(POOL_CAP), .WIDTH(ID_W)) u_free_stack (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata)
	);

	hpa_ram #(.DEPTH(POOL_CAP), .WIDTH(ID_W)) u_active_list (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(al_raddr), .rdata(al_rdata)
	);

	hpa_id_map u_id_map (
		.clk(clk), .arst_n(arst_n), .cmd(id_cmd), .in_use(id_used)
	);

	assign cfg_ready    = 1'b1;
	assign req_ready    = (state_q == S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign handle_out   = handle_out_q;
	assign status       = status_q;
	assign busy_count   = act_out_q;
	assign free_count   = free_out_q;
	assign total_count  = tot_out_q;

	// growth sizing
	always_comb begin
		total = free_len_q + active_len_q;
		lim   = (cap_lim_q == '0 || cap_lim_q > CAP) ? CAP : cap_lim_q;
		room  = (total < lim) ? lim - total : '0;
		half  = ({1'b0, total} + (CNT_W+1)'(1)) >> 1;
		unique case (growth_t'(grow_mode_q))
			GROW_FIXED:  amt_grow = '0;
			GROW_LINEAR: amt_grow = (init_cap_q != '0) ? init_cap_q : DEF_GRW;
			GROW_DOUBLE: amt_grow = (total != '0) ? total : DEF_GRW;
			default:     amt_grow = (total != '0) ? half[CNT_W-1:0] : DEF_GRW;
		endcase
		amt_pre = (target_count > total) ? target_count - total : '0;
		unique case (mode_t'(mode))
			MODE_PREWARM:   req_amt = amt_pre;
			MODE_CONSTRUCT: req_amt = init_cap_q;
			default:        req_amt = amt_grow;
		endcase
		clip = (req_amt > room) ? room : req_amt;
	end

	// memory and id map access
	always_comb begin
		fs_we    = 1'b0;
		fs_waddr = free_len_q[ID_W-1:0];
		fs_wdata = id_q[ID_W-1:0];
		fs_raddr = free_len_q[ID_W-1:0] - ID_W'(1);
		al_we    = 1'b0;
		al_waddr = active_len_q[ID_W-1:0];
		al_wdata = fs_rdata;
		al_raddr = idx_q[ID_W-1:0];
		id_cmd   = '{set: 1'b0, clr: 1'b0, clr_all: 1'b0, idx: id_q[ID_W-1:0]};
		unique case (state_q)
			S_GROW: begin
				if (cnt_q != '0 && id_q < CAP && !id_used && free_len_q < CAP) begin
					fs_we      = 1'b1;
					id_cmd.set = 1'b1;
				end
			end
			S_ACQ_WR: al_we = 1'b1;
			S_REL_CMP: al_raddr = active_len_q[ID_W-1:0] - ID_W'(1);
			S_REL_MOVE: begin
				al_we    = 1'b1;
				al_waddr = idx_q[ID_W-1:0];
				al_wdata = al_rdata;
				fs_we    = (free_len_q < CAP);
				fs_wdata = handle_q;
			end
			S_SHR_CLR: begin
				id_cmd.clr = 1'b1;
				id_cmd.idx = fs_rdata;
			end
			S_RALL: al_raddr = active_len_q[ID_W-1:0] - ID_W'(1);
			S_RALL_WR: begin
				fs_we    = (free_len_q < CAP);
				fs_wdata = al_rdata;
			end
			S_IDLE: id_cmd.clr_all = req_valid && (mode_t'(mode) == MODE_CLEAR);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			init_cap_q   <= '0;
			cap_lim_q    <= '0;
			grow_mode_q  <= GROW_DOUBLE;
			free_len_q   <= '0;
			active_len_q <= '0;
			rsp_valid_q  <= 1'b0;
			ret_acq_q    <= 1'b0;
			cnt_q        <= '0;
			id_q         <= '0;
			idx_q        <= '0;
			keep_q       <= '0;
			st_q         <= ST_OK;
			handle_q     <= '0;
			hout_q       <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_INITIAL_CAPACITY: init_cap_q  <= cfg_data;
					REG_CAPACITY_LIMIT:   cap_lim_q   <= cfg_data;
					REG_GROWTH_MODE:      grow_mode_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						handle_q  <= handle_in;
						hout_q    <= '0;
						st_q      <= (mode_t'(mode) == MODE_RELEASE) ? ST_NOT_ACTIVE : ST_OK;
						cnt_q     <= clip;
						id_q      <= '0;
						idx_q     <= '0;
						ret_acq_q <= (mode_t'(mode) == MODE_ACQUIRE);
						keep_q    <= (init_cap_q > active_len_q) ?
							init_cap_q - active_len_q : '0;
						unique case (mode_t'(mode))
							MODE_ACQUIRE: begin
								state_q   <= (free_len_q == '0) ? S_GROW : S_ACQ_CHK;
							end
							MODE_RELEASE: begin
								state_q <= S_REL_RD;
							end
							MODE_PREWARM, MODE_CONSTRUCT: state_q <= S_GROW;
							MODE_SHRINK:      state_q <= S_SHR;
							MODE_CLEAR: begin
								free_len_q   <= '0;
								active_len_q <= '0;
								state_q      <= S_DONE;
							end
							MODE_RELEASE_ALL: state_q <= S_RALL;
							default:          state_q <= S_DONE;
						endcase
					end
				end
				S_GROW: begin
					if (cnt_q == '0 || id_q >= CAP) begin
						state_q <= ret_acq_q ? S_ACQ_CHK : S_DONE;
					end else begin
						if (!id_used && free_len_q < CAP) begin
							free_len_q <= free_len_q + CNT_W'(1);
							cnt_q      <= cnt_q - CNT_W'(1);
						end
						id_q <= id_q + CNT_W'(1);
					end
				end
				S_ACQ_CHK: begin
					if (free_len_q == '0 || active_len_q >= CAP) begin
						st_q    <= ST_EXHAUSTED;
						state_q <= S_DONE;
					end else begin
						free_len_q <= free_len_q - CNT_W'(1);
						state_q    <= S_ACQ_WR;
					end
				end
				S_ACQ_WR: begin
					hout_q       <= fs_rdata;
					active_len_q <= active_len_q + CNT_W'(1);
					state_q      <= S_DONE;
				end
				S_REL_RD: begin
					state_q <= (idx_q >= active_len_q) ? S_DONE : S_REL_CMP;
				end
				S_REL_CMP: begin
					if (al_rdata == handle_q) begin
						active_len_q <= active_len_q - CNT_W'(1);
						state_q      <= S_REL_MOVE;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_REL_RD;
					end
				end
				S_REL_MOVE: begin
					if (free_len_q < CAP) begin
						free_len_q <= free_len_q + CNT_W'(1);
					end
					st_q    <= ST_OK;
					state_q <= S_DONE;
				end
				S_SHR: begin
					if (free_len_q > keep_q) begin
						free_len_q <= free_len_q - CNT_W'(1);
						state_q    <= S_SHR_CLR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHR_CLR: state_q <= S_SHR;
				S_RALL: begin
					if (active_len_q != '0) begin
						active_len_q <= active_len_q - CNT_W'(1);
						state_q      <= S_RALL_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RALL_WR: begin
					if (free_len_q < CAP) begin
						free_len_q <= free_len_q + CNT_W'(1);
					end
					state_q <= S_RALL;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			handle_out_q <= hout_q;
			status_q     <= st_q;
			act_out_q    <= active_len_q;
			free_out_q   <= free_len_q;
			tot_out_q    <= total;
		end
	end

endmodule
